>>> hw/rtl/twdg_pkg.sv
// shared types and constants for the triangle wave dac generator
package twdg_pkg;

  localparam int DAC_BITS_DEF = 12;
  localparam int TICK_W       = 16;
  localparam int CODE_W       = 13;
  localparam int DVD_W        = 32;
  localparam int CNT_W        = 6;
  localparam int ADDR_W       = 5;
  localparam int DATA_W       = 32;

  localparam logic [CNT_W-1:0] STEPS_LONG  = CNT_W'(DVD_W);
  localparam logic [CNT_W-1:0] STEPS_SHORT = CNT_W'(TICK_W);

  localparam logic [TICK_W-1:0] PERIOD_RST = 16'd60;
  localparam logic [TICK_W-1:0] RISE_RST   = 16'd60;
  localparam logic [TICK_W-1:0] FALL_RST   = 16'd0;
  localparam logic [CODE_W-1:0] AMP_RST    = 13'd2457;
  localparam logic [CODE_W-1:0] OFF_RST    = 13'd819;

  // register indexes on the configuration port
  localparam logic [2:0] REG_PERIOD = 3'd0;
  localparam logic [2:0] REG_RISE   = 3'd1;
  localparam logic [2:0] REG_FALL   = 3'd2;
  localparam logic [2:0] REG_AMP    = 3'd3;
  localparam logic [2:0] REG_OFF    = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOD_GO,
    ST_MOD_WAIT,
    ST_SEL,
    ST_MUL_A,
    ST_MUL_B,
    ST_SUM,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_CLAMP
  } state_t;

  typedef struct packed {
    logic start;
    logic long_op;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> hw/rtl/twdg_div.sv
// iterative restoring divider shared by the phase modulo and the slope divide
module twdg_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  twdg_pkg::div_req_t            req,
  input  logic [twdg_pkg::DVD_W-1:0]    dividend,
  input  logic [twdg_pkg::TICK_W-1:0]   divisor,
  output twdg_pkg::div_stat_t           stat,
  output logic [twdg_pkg::DVD_W-1:0]    quotient,
  output logic [twdg_pkg::TICK_W-1:0]   remainder
);

  logic                         busy_r;
  logic [twdg_pkg::CNT_W-1:0]   cnt_r;
  logic [twdg_pkg::DVD_W-1:0]   dvd_r;
  logic [twdg_pkg::TICK_W:0]    rem_r;
  logic [twdg_pkg::TICK_W-1:0]  dsr_r;
  logic [twdg_pkg::TICK_W:0]    rem_sh;
  logic [twdg_pkg::TICK_W+1:0]  diff;
  logic                         qbit;
  logic [twdg_pkg::TICK_W:0]    rem_nxt;

  always_comb begin
    rem_sh  = {rem_r[twdg_pkg::TICK_W-1:0], dvd_r[twdg_pkg::DVD_W-1]};
    diff    = {1'b0, rem_sh} - {2'b00, dsr_r};
    qbit    = ~diff[twdg_pkg::TICK_W+1];
    rem_nxt = qbit ? diff[twdg_pkg::TICK_W:0] : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      cnt_r  <= req.long_op ? twdg_pkg::STEPS_LONG : twdg_pkg::STEPS_SHORT;
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // quotient bits shift in at the bottom of the dividend register
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r && cnt_r != '0) begin
      dvd_r <= {dvd_r[twdg_pkg::DVD_W-2:0], qbit};
      rem_r <= rem_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = busy_r && (cnt_r == '0);
  assign quotient  = dvd_r;
  assign remainder = rem_r[twdg_pkg::TICK_W-1:0];

endmodule

>>> hw/rtl/triangle_wave_dac_generator.sv
// top level: asymmetric triangle / sawtooth dac code generator
//
// usage: each word on the input channel carries in_advance. with advance set
// the tick counter moves on by one and wraps to 1 once it passes the period;
// with advance clear the current sample is recomputed. every input word gives
// exactly one output word: the dac code plus high and low clamp flags.
// operation: one input word at a time. after acceptance the sequencer runs a
// 16-step modulo of the tick counter by the period, two products through one
// shared multiplier, then a 32-step divide; the modulo and the divide share
// one radix-2 restoring divider. a zero period skips the modulo, and a zero
// slope length skips both products and the divide. in_ready is high only
// while the sequencer is idle, so a new word is not taken until the last
// result has been loaded into the output register.
// the output word sits in a register; a new input can be accepted while it
// waits, and a stalled receiver holds the next result in its final step
// until the register frees up.
// reset (rst_n low, synchronous) clears the tick counter, drops out_valid and
// loads the register defaults: period 60, rise 60, fall 0, amplitude 2457,
// offset 819. registers sit at byte addresses 0, 4, 8, 12, 16 and should
// be written only while the block is idle.
module triangle_wave_dac_generator #(
  parameter int DAC_BITS = twdg_pkg::DAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_advance,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [DAC_BITS-1:0]            out_dac_code,
  output logic                           out_clamped_high,
  output logic                           out_clamped_low,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [twdg_pkg::ADDR_W-1:0]    paddr,
  input  logic [twdg_pkg::DATA_W-1:0]    pwdata,
  output logic [twdg_pkg::DATA_W-1:0]    prdata,
  output logic                           pready
);

  localparam int TW = twdg_pkg::TICK_W;
  localparam int CW = twdg_pkg::CODE_W;
  localparam int DW = twdg_pkg::DVD_W;
  localparam logic signed [DW-1:0] MAX_CODE = DW'((64'd1 << DAC_BITS) - 64'd1);

  // configuration registers
  logic [TW-1:0] period_r, rise_r, fall_r;
  logic [CW-1:0] amp_r, off_r;
  logic          cfg_wr;
  logic [2:0]    reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[twdg_pkg::ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= twdg_pkg::PERIOD_RST;
      rise_r   <= twdg_pkg::RISE_RST;
      fall_r   <= twdg_pkg::FALL_RST;
      amp_r    <= twdg_pkg::AMP_RST;
      off_r    <= twdg_pkg::OFF_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        twdg_pkg::REG_PERIOD: period_r <= pwdata[TW-1:0];
        twdg_pkg::REG_RISE:   rise_r   <= pwdata[TW-1:0];
        twdg_pkg::REG_FALL:   fall_r   <= pwdata[TW-1:0];
        twdg_pkg::REG_AMP:    amp_r    <= pwdata[CW-1:0];
        twdg_pkg::REG_OFF:    off_r    <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      twdg_pkg::REG_PERIOD: prdata = {{(twdg_pkg::DATA_W-TW){1'b0}}, period_r};
      twdg_pkg::REG_RISE:   prdata = {{(twdg_pkg::DATA_W-TW){1'b0}}, rise_r};
      twdg_pkg::REG_FALL:   prdata = {{(twdg_pkg::DATA_W-TW){1'b0}}, fall_r};
      twdg_pkg::REG_AMP:    prdata = {{(twdg_pkg::DATA_W-CW){1'b0}}, amp_r};
      twdg_pkg::REG_OFF:    prdata = {{(twdg_pkg::DATA_W-CW){1'b0}}, off_r};
      default:              prdata = '0;
    endcase
  end

  // sequencer
  twdg_pkg::state_t    state_r, state_nxt;
  twdg_pkg::div_req_t  div_req;
  twdg_pkg::div_stat_t div_stat;
  logic [DW-1:0]       div_dividend;
  logic [TW-1:0]       div_divisor;
  logic [DW-1:0]       div_quot;
  logic [TW-1:0]       div_rem;

  logic [TW-1:0]       tp_r;
  logic [TW:0]         tp_sum;
  logic [TW-1:0]       phase_r;
  logic                falling_r;
  logic                neg_r;
  logic signed [DW-2:0] prod_r;
  logic signed [DW-1:0] acc_r;
  logic signed [DW-1:0] val_r;
  logic                in_acc, out_free;

  logic signed [CW:0]   amp_x, off_x, peak;
  logic signed [CW:0]   mul_a;
  logic signed [TW:0]   mul_b;
  logic signed [DW-2:0] mul_p;
  logic [TW-1:0]        phase_dif;
  logic                 fall_now;
  logic                 zero_div;
  logic                 clamp_hi, clamp_lo;

  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign tp_sum   = {1'b0, tp_r} + {{TW{1'b0}}, 1'b1};

  assign amp_x = {amp_r[CW-1], amp_r};
  assign off_x = {off_r[CW-1], off_r};
  assign peak  = amp_x + off_x;

  assign phase_dif = phase_r - rise_r;
  assign fall_now  = phase_r > rise_r;
  assign zero_div  = fall_now ? (fall_r == '0) : (rise_r == '0);

  // one shared signed multiplier, operands chosen by step and slope
  always_comb begin
    if (state_r == twdg_pkg::ST_MUL_A) begin
      mul_a = falling_r ? peak : amp_x;
      mul_b = falling_r ? $signed({1'b0, fall_r}) : $signed({1'b0, phase_r});
    end else begin
      mul_a = falling_r ? amp_x : off_x;
      mul_b = falling_r ? $signed({1'b0, phase_dif}) : $signed({1'b0, rise_r});
    end
    mul_p = (DW-1)'(mul_a) * (DW-1)'(mul_b);
  end

  assign clamp_hi = val_r > MAX_CODE;
  assign clamp_lo = val_r[DW-1];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      twdg_pkg::ST_IDLE:     if (in_acc) state_nxt = twdg_pkg::ST_MOD_GO;
      twdg_pkg::ST_MOD_GO:   state_nxt = (period_r == '0) ? twdg_pkg::ST_SEL
                                                          : twdg_pkg::ST_MOD_WAIT;
      twdg_pkg::ST_MOD_WAIT: if (div_stat.done) state_nxt = twdg_pkg::ST_SEL;
      twdg_pkg::ST_SEL:      state_nxt = zero_div ? twdg_pkg::ST_CLAMP
                                                  : twdg_pkg::ST_MUL_A;
      twdg_pkg::ST_MUL_A:    state_nxt = twdg_pkg::ST_MUL_B;
      twdg_pkg::ST_MUL_B:    state_nxt = twdg_pkg::ST_SUM;
      twdg_pkg::ST_SUM:      state_nxt = twdg_pkg::ST_DIV_GO;
      twdg_pkg::ST_DIV_GO:   state_nxt = twdg_pkg::ST_DIV_WAIT;
      twdg_pkg::ST_DIV_WAIT: if (div_stat.done) state_nxt = twdg_pkg::ST_CLAMP;
      twdg_pkg::ST_CLAMP:    if (out_free) state_nxt = twdg_pkg::ST_IDLE;
      default:               state_nxt = twdg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = 1'b0;
    div_req.start   = 1'b0;
    div_req.long_op = 1'b0;
    div_dividend    = acc_r[DW-1] ? DW'(-acc_r) : DW'(acc_r);
    div_divisor     = falling_r ? fall_r : rise_r;
    case (state_r)
      twdg_pkg::ST_IDLE: in_ready = 1'b1;
      twdg_pkg::ST_MOD_GO: begin
        div_req.start = (period_r != '0);
        div_dividend  = {tp_r, {(DW-TW){1'b0}}};
        div_divisor   = period_r;
      end
      twdg_pkg::ST_DIV_GO: begin
        div_req.start   = 1'b1;
        div_req.long_op = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= twdg_pkg::ST_IDLE;
      tp_r    <= '0;
    end else begin
      state_r <= state_nxt;
      // wrap back to 1 once the counter passes the period
      if (in_acc && in_advance) begin
        tp_r <= (tp_sum > {1'b0, period_r}) ? {{(TW-1){1'b0}}, 1'b1} : tp_sum[TW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      twdg_pkg::ST_MOD_GO: phase_r <= tp_r;
      twdg_pkg::ST_MOD_WAIT: if (div_stat.done) phase_r <= div_rem;
      twdg_pkg::ST_SEL: begin
        falling_r <= fall_now;
        val_r     <= DW'(peak);
      end
      twdg_pkg::ST_MUL_A: prod_r <= mul_p;
      twdg_pkg::ST_MUL_B: begin
        prod_r <= mul_p;
        acc_r  <= DW'(prod_r);
      end
      twdg_pkg::ST_SUM: acc_r <= falling_r ? acc_r - DW'(prod_r) : acc_r + DW'(prod_r);
      twdg_pkg::ST_DIV_GO: neg_r <= acc_r[DW-1];
      // magnitude divide, sign put back: truncation toward zero
      twdg_pkg::ST_DIV_WAIT: if (div_stat.done) val_r <= neg_r ? -$signed(div_quot)
                                                               : $signed(div_quot);
      default: ;
    endcase
  end

  twdg_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (div_req),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .stat      (div_stat),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // output register
  logic                out_valid_r;
  logic [DAC_BITS-1:0] out_code_r;
  logic                out_hi_r, out_lo_r;
  logic                out_load;

  assign out_load = (state_r == twdg_pkg::ST_CLAMP) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_hi_r   <= clamp_hi;
      out_lo_r   <= clamp_lo;
      out_code_r <= clamp_hi ? MAX_CODE[DAC_BITS-1:0]
                  : clamp_lo ? '0 : val_r[DAC_BITS-1:0];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_dac_code     = out_code_r;
  assign out_clamped_high = out_hi_r;
  assign out_clamped_low  = out_lo_r;

  a_acc_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == twdg_pkg::ST_MOD_GO)
    else $error("accepted word did not start the sequencer");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_clamped_high && out_clamped_low))
    else $error("both clamp flags set");

  a_high_is_max: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_clamped_high) |-> out_dac_code == MAX_CODE[DAC_BITS-1:0])
    else $error("high clamp without full scale code");

  a_low_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_clamped_low) |-> out_dac_code == '0)
    else $error("low clamp without zero code");

  a_advance_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_advance) |=> tp_r != '0)
    else $error("tick counter zero after advance");

endmodule
